// ===== rtl/core/tpc_pkg.sv =====
package tpc_pkg;

    // Coordinate format
    localparam int CW        = 32;          // coordinate width
    localparam int FB        = 16;          // fraction bits
    // Derived datapath widths
    localparam int QW        = CW + 1;      // edge difference / quotient width
    localparam int DW        = 2 * CW + 2;  // signed plane distance width
    localparam int NW        = DW;          // intersection numerator width
    localparam int DENW      = DW + 1;      // intersection denominator width
    localparam int PW        = NW + QW;     // full product width
    localparam int SW        = CW + 2;      // sum width before clamping
    localparam int ISECT_LAT = QW + 3;      // edge divider latency
    localparam int ADDR_W    = 4;

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_PLANE_A = 2'd0;
    localparam reg_idx_t REG_PLANE_B = 2'd1;
    localparam reg_idx_t REG_PLANE_C = 2'd2;
    localparam reg_idx_t REG_PLANE_D = 2'd3;

    typedef logic signed [CW-1:0] coord_t;

    // element 0 is x, 1 is y, 2 is z
    typedef coord_t [2:0] vert_t;

    typedef struct packed {
        coord_t x0;
        coord_t y0;
        coord_t z0;
        coord_t x1;
        coord_t y1;
        coord_t z1;
        coord_t x2;
        coord_t y2;
        coord_t z2;
    } in_beat_t;

    typedef struct packed {
        coord_t     out_x0;
        coord_t     out_y0;
        coord_t     out_z0;
        coord_t     out_x1;
        coord_t     out_y1;
        coord_t     out_z1;
        coord_t     out_x2;
        coord_t     out_y2;
        coord_t     out_z2;
        logic [2:0] new_vertex_mask;
        logic       last;
    } out_beat_t;

    // source of one output vertex slot
    typedef logic [2:0] src_t;
    localparam src_t SRC_V0 = 3'd0;
    localparam src_t SRC_V1 = 3'd1;
    localparam src_t SRC_V2 = 3'd2;
    localparam src_t SRC_IA = 3'd3;
    localparam src_t SRC_IB = 3'd4;

    typedef struct packed {
        logic [1:0]     nres;
        src_t [2:0]     sel0;
        logic [2:0]     mask0;
        src_t [2:0]     sel1;
        logic [2:0]     mask1;
    } plan_t;

    typedef struct packed {
        vert_t [2:0] v;
        plan_t       plan;
    } side_t;

endpackage

// ===== rtl/core/tpc_edge_div.sv =====
module tpc_edge_div
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [tpc_pkg::NW-1:0]   num,
    input  logic [tpc_pkg::QW-1:0]   mag,
    input  logic                     neg,
    input  logic [tpc_pkg::DENW-1:0] den,
    input  tpc_pkg::coord_t          start,
    output tpc_pkg::coord_t          coord
);
    import tpc_pkg::*;

    // partial products of numerator halves and edge magnitude
    logic [2*QW-1:0] lo_prod_reg;
    logic [2*QW-1:0] hi_prod_reg;
    logic [DENW-1:0] den_a_reg;
    logic            neg_a_reg;
    coord_t          start_a_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_prod_reg <= (2*QW)'(num[QW-1:0]) * (2*QW)'(mag);
            hi_prod_reg <= (2*QW)'(num[NW-1:QW]) * (2*QW)'(mag);
            den_a_reg   <= den;
            neg_a_reg   <= neg;
            start_a_reg <= start;
        end
    end

    logic [PW-1:0] prod;
    assign prod = (PW'(hi_prod_reg) << QW) + PW'(lo_prod_reg);

    // restoring division, one quotient bit per stage
    logic [DENW-1:0] rem_reg   [QW+1];
    logic [QW-1:0]   low_reg   [QW+1];
    logic [QW-1:0]   quo_reg   [QW+1];
    logic [DENW-1:0] den_reg   [QW+1];
    logic            neg_reg   [QW+1];
    coord_t          start_reg [QW+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]   <= DENW'(prod[PW-1:QW]);
            low_reg[0]   <= prod[QW-1:0];
            quo_reg[0]   <= '0;
            den_reg[0]   <= den_a_reg;
            neg_reg[0]   <= neg_a_reg;
            start_reg[0] <= start_a_reg;
        end
    end

    for (genvar j = 0; j < QW; j++)
    begin : g_step
        logic [DENW:0] trial;
        logic [DENW:0] dif;
        logic          ge;

        always_comb
        begin
            trial = {rem_reg[j], low_reg[j][QW-1]};
            dif   = trial - {1'b0, den_reg[j]};
            ge    = (trial >= {1'b0, den_reg[j]});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1]   <= ge ? dif[DENW-1:0] : trial[DENW-1:0];
                low_reg[j+1]   <= {low_reg[j][QW-2:0], 1'b0};
                quo_reg[j+1]   <= {quo_reg[j][QW-2:0], ge};
                den_reg[j+1]   <= den_reg[j];
                neg_reg[j+1]   <= neg_reg[j];
                start_reg[j+1] <= start_reg[j];
            end
        end
    end

    // sign, offset by start vertex, clamp
    logic signed [SW-1:0] qmag;
    logic signed [SW-1:0] qsig;
    logic signed [SW-1:0] sum;
    logic [SW-CW:0]       top;
    coord_t               sat;
    coord_t               coord_reg;

    always_comb
    begin
        qmag = $signed({1'b0, quo_reg[QW]});
        qsig = neg_reg[QW] ? -qmag : qmag;
        sum  = SW'(start_reg[QW]) + qsig;
        top  = sum[SW-1:CW-1];
        if (top == '0 || top == '1)
            sat = sum[CW-1:0];
        else if (sum[SW-1])
            sat = {1'b1, {(CW-1){1'b0}}};
        else
            sat = {1'b0, {(CW-1){1'b1}}};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            coord_reg <= sat;
    end

    assign coord = coord_reg;

endmodule

// ===== rtl/core/triangle_plane_clipper.sv =====
// An accepted triangle passes the plane-product, distance and edge set-up
// stages, the edge dividers and the output register before clip_valid rises.
// Throughput: one triangle per cycle when it yields one result and clip_ready
// is high; two results stall it, as one output register serializes the beats.
// The 33-stage restoring divider per edge coordinate sets the depth.
// Reset (rst_n, async, active low) empties the pipeline; plane = (0,0,-1,-1).
module triangle_plane_clipper
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tpc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       tri_valid,
    output logic                       tri_ready,
    input  tpc_pkg::in_beat_t          tri_data,
    output logic                       clip_valid,
    input  logic                       clip_ready,
    output tpc_pkg::out_beat_t         clip_data
);
    import tpc_pkg::*;

    // ---------------- configuration ----------------
    coord_t   plane_a_reg;
    coord_t   plane_b_reg;
    coord_t   plane_c_reg;
    coord_t   plane_d_reg;
    reg_idx_t cfg_idx;

    assign cfg_idx = paddr[3:2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_a_reg <= '0;
            plane_b_reg <= '0;
            plane_c_reg <= -(CW'(1) << FB);
            plane_d_reg <= -(CW'(1) << FB);
        end
        else if (psel && penable && pwrite)
        begin
            case (cfg_idx)
                REG_PLANE_A: plane_a_reg <= pwdata;
                REG_PLANE_B: plane_b_reg <= pwdata;
                REG_PLANE_C: plane_c_reg <= pwdata;
                REG_PLANE_D: plane_d_reg <= pwdata;
                default:     plane_a_reg <= plane_a_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_PLANE_A: prdata = plane_a_reg;
            REG_PLANE_B: prdata = plane_b_reg;
            REG_PLANE_C: prdata = plane_c_reg;
            REG_PLANE_D: prdata = plane_d_reg;
            default:     prdata = '0;
        endcase
    end

    // global advance: the whole pipeline moves when the output can take it
    logic en;

    // ---------------- stage 1: plane products ----------------
    vert_t [2:0]              v_in;
    logic signed [2*CW-1:0]   prod_reg [3][3];
    vert_t [2:0]              v1_reg;
    logic                     valid1_reg;

    assign v_in[0] = {tri_data.z0, tri_data.y0, tri_data.x0};
    assign v_in[1] = {tri_data.z1, tri_data.y1, tri_data.x1};
    assign v_in[2] = {tri_data.z2, tri_data.y2, tri_data.x2};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i][0] <= (2*CW)'(plane_a_reg) * (2*CW)'($signed(v_in[i][0]));
                prod_reg[i][1] <= (2*CW)'(plane_b_reg) * (2*CW)'($signed(v_in[i][1]));
                prod_reg[i][2] <= (2*CW)'(plane_c_reg) * (2*CW)'($signed(v_in[i][2]));
            end
            v1_reg <= v_in;
        end
    end

    // ---------------- stage 2: distances ----------------
    logic signed [DW-1:0] dterm;
    logic signed [DW-1:0] dist_reg [3];
    vert_t [2:0]          v2_reg;
    logic                 valid2_reg;

    assign dterm = DW'(plane_d_reg) <<< FB;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                dist_reg[i] <= DW'(prod_reg[i][0]) + DW'(prod_reg[i][1])
                             + DW'(prod_reg[i][2]) + dterm;
            v2_reg <= v1_reg;
        end
    end

    // ---------------- stage 3: classify, set up edges ----------------
    logic [2:0]             ins;
    plan_t                  plan;
    logic [1:0]             s_idx [2];
    logic [1:0]             e_idx [2];
    logic signed [DW-1:0]   ds    [2];
    logic signed [DW-1:0]   de    [2];
    logic signed [DENW-1:0] dd    [2];
    logic signed [QW-1:0]   diff  [2][3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            ins[i] = !dist_reg[i][DW-1] && (dist_reg[i] != '0);

        plan       = '0;
        plan.sel0  = {SRC_V2, SRC_V1, SRC_V0};
        plan.sel1  = {SRC_V2, SRC_V1, SRC_V0};
        s_idx[0]   = 2'd0;
        e_idx[0]   = 2'd1;
        s_idx[1]   = 2'd0;
        e_idx[1]   = 2'd2;
        case (ins)
            3'b111:
            begin
                plan.nres = 2'd1;
            end
            3'b011:
            begin
                s_idx[0] = 2'd0; e_idx[0] = 2'd2;
                s_idx[1] = 2'd1; e_idx[1] = 2'd2;
                plan.nres  = 2'd2;
                plan.sel0  = {SRC_V0, SRC_V1, SRC_IA};
                plan.mask0 = 3'b001;
                plan.sel1  = {SRC_V1, SRC_IB, SRC_IA};
                plan.mask1 = 3'b011;
            end
            3'b101:
            begin
                s_idx[0] = 2'd0; e_idx[0] = 2'd1;
                s_idx[1] = 2'd2; e_idx[1] = 2'd1;
                plan.nres  = 2'd2;
                plan.sel0  = {SRC_V0, SRC_V2, SRC_IA};
                plan.mask0 = 3'b001;
                plan.sel1  = {SRC_V2, SRC_IB, SRC_IA};
                plan.mask1 = 3'b011;
            end
            3'b110:
            begin
                s_idx[0] = 2'd0; e_idx[0] = 2'd1;
                s_idx[1] = 2'd0; e_idx[1] = 2'd2;
                plan.nres  = 2'd2;
                plan.sel0  = {SRC_V1, SRC_V2, SRC_IA};
                plan.mask0 = 3'b001;
                plan.sel1  = {SRC_V2, SRC_IB, SRC_IA};
                plan.mask1 = 3'b011;
            end
            3'b001:
            begin
                s_idx[0] = 2'd1; e_idx[0] = 2'd0;
                s_idx[1] = 2'd2; e_idx[1] = 2'd0;
                plan.nres  = 2'd1;
                plan.sel0  = {SRC_IB, SRC_IA, SRC_V0};
                plan.mask0 = 3'b110;
            end
            3'b010:
            begin
                s_idx[0] = 2'd0; e_idx[0] = 2'd1;
                s_idx[1] = 2'd2; e_idx[1] = 2'd1;
                plan.nres  = 2'd1;
                plan.sel0  = {SRC_IB, SRC_V1, SRC_IA};
                plan.mask0 = 3'b101;
            end
            3'b100:
            begin
                s_idx[0] = 2'd0; e_idx[0] = 2'd2;
                s_idx[1] = 2'd1; e_idx[1] = 2'd2;
                plan.nres  = 2'd1;
                plan.sel0  = {SRC_V2, SRC_IB, SRC_IA};
                plan.mask0 = 3'b011;
            end
            default:
            begin
                plan.nres = 2'd0;
            end
        endcase

        for (int u = 0; u < 2; u++)
        begin
            ds[u] = dist_reg[s_idx[u]];
            de[u] = dist_reg[e_idx[u]];
            dd[u] = DENW'(de[u]) - DENW'(ds[u]);
            for (int k = 0; k < 3; k++)
                diff[u][k] = QW'($signed(v2_reg[e_idx[u]][k]))
                           - QW'($signed(v2_reg[s_idx[u]][k]));
        end
    end

    side_t           side3_reg;
    logic            valid3_reg;
    logic [NW-1:0]   num_reg   [2];
    logic [DENW-1:0] den_reg   [2];
    logic [QW-1:0]   mag_reg   [2][3];
    logic            neg_reg   [2][3];
    coord_t          start_reg [2][3];

    // one end is inside and the other not, so -ds/(de-ds) is never negative:
    // the divider takes magnitudes and the sign comes from the edge delta
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side3_reg.v    <= v2_reg;
            side3_reg.plan <= plan;
            for (int u = 0; u < 2; u++)
            begin
                num_reg[u] <= ds[u][DW-1] ? NW'(-ds[u]) : NW'(ds[u]);
                den_reg[u] <= dd[u][DENW-1] ? DENW'(-dd[u]) : DENW'(dd[u]);
                for (int k = 0; k < 3; k++)
                begin
                    neg_reg[u][k]   <= diff[u][k][QW-1];
                    mag_reg[u][k]   <= diff[u][k][QW-1] ? QW'(-diff[u][k]) : QW'(diff[u][k]);
                    start_reg[u][k] <= v2_reg[s_idx[u]][k];
                end
            end
        end
    end

    // ---------------- edge intersection units ----------------
    vert_t [1:0] isect;

    for (genvar u = 0; u < 2; u++)
    begin : g_unit
        for (genvar k = 0; k < 3; k++)
        begin : g_coord
            tpc_edge_div u_div
            (
                .clk   (clk),
                .en    (en),
                .num   (num_reg[u]),
                .mag   (mag_reg[u][k]),
                .neg   (neg_reg[u][k]),
                .den   (den_reg[u]),
                .start (start_reg[u][k]),
                .coord (isect[u][k])
            );
        end
    end

    // sideband delay matched to the divider
    side_t side_pipe_reg  [ISECT_LAT];
    logic  valid_pipe_reg [ISECT_LAT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_pipe_reg[0] <= side3_reg;
            for (int s = 1; s < ISECT_LAT; s++)
                side_pipe_reg[s] <= side_pipe_reg[s-1];
        end
    end

    // ---------------- output register ----------------
    side_t       hold_reg;
    vert_t [1:0] hold_isect_reg;
    logic        hold_valid_reg;
    logic        beat_sel_reg;
    logic        final_beat;

    assign final_beat = (hold_reg.plan.nres != 2'd2) || beat_sel_reg;
    assign en         = !hold_valid_reg || (clip_ready && final_beat);
    assign tri_ready  = en;
    assign clip_valid = hold_valid_reg;

    // valid bits of every stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg     <= 1'b0;
            valid2_reg     <= 1'b0;
            valid3_reg     <= 1'b0;
            for (int s = 0; s < ISECT_LAT; s++)
                valid_pipe_reg[s] <= 1'b0;
            hold_valid_reg <= 1'b0;
            beat_sel_reg   <= 1'b0;
        end
        else if (en)
        begin
            valid1_reg        <= tri_valid;
            valid2_reg        <= valid1_reg;
            valid3_reg        <= valid2_reg;
            valid_pipe_reg[0] <= valid3_reg;
            for (int s = 1; s < ISECT_LAT; s++)
                valid_pipe_reg[s] <= valid_pipe_reg[s-1];
            hold_valid_reg    <= valid_pipe_reg[ISECT_LAT-1]
                              && (side_pipe_reg[ISECT_LAT-1].plan.nres != 2'd0);
            beat_sel_reg      <= 1'b0;
        end
        else if (clip_valid && clip_ready)
        begin
            beat_sel_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hold_reg       <= side_pipe_reg[ISECT_LAT-1];
            hold_isect_reg <= isect;
        end
    end

    // beat assembly
    src_t [2:0] sel;
    vert_t      slot [3];

    always_comb
    begin
        sel = beat_sel_reg ? hold_reg.plan.sel1 : hold_reg.plan.sel0;
        for (int s = 0; s < 3; s++)
        begin
            case (sel[s])
                SRC_V0:  slot[s] = hold_reg.v[0];
                SRC_V1:  slot[s] = hold_reg.v[1];
                SRC_V2:  slot[s] = hold_reg.v[2];
                SRC_IA:  slot[s] = hold_isect_reg[0];
                SRC_IB:  slot[s] = hold_isect_reg[1];
                default: slot[s] = '0;
            endcase
        end
        clip_data.out_x0          = slot[0][0];
        clip_data.out_y0          = slot[0][1];
        clip_data.out_z0          = slot[0][2];
        clip_data.out_x1          = slot[1][0];
        clip_data.out_y1          = slot[1][1];
        clip_data.out_z1          = slot[1][2];
        clip_data.out_x2          = slot[2][0];
        clip_data.out_y2          = slot[2][1];
        clip_data.out_z2          = slot[2][2];
        clip_data.new_vertex_mask = beat_sel_reg ? hold_reg.plan.mask1 : hold_reg.plan.mask0;
        clip_data.last            = final_beat;
    end

endmodule
